[hdl/alid_pkg.sv]
// shared opcodes, status codes and command bundle for the array list core
package alid_pkg;

  localparam int OPC_W = 3;
  localparam int POS_W = 4;
  localparam int ST_W  = 2;

  localparam logic [OPC_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPC_W-1:0] OP_READ   = 3'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;        // a beat is accepted this cycle
    logic shift_down;  // delete: cells at and above position take their upper neighbor
    logic shift_up;    // insert: cells above position take their lower neighbor
    logic write_tail;  // append at the current count
    logic rd;          // read the cell at position
  } alid_cmd_t;

endpackage

[hdl/alid_ctrl.sv]
// controller: handshake, opcode decode, range checks, count and status registers
module alid_ctrl
  import alid_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5,
  parameter int IDX_W    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OPC_W-1:0] in_opcode,
  input  logic [POS_W-1:0] in_position,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] out_element_count,
  output logic [ST_W-1:0]  out_status,
  output alid_cmd_t        cmd,
  output logic [IDX_W-1:0] pos_idx,
  output logic [IDX_W-1:0] tail_idx
);

  localparam int CMP_W = CNT_W + POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] res_count_r;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [CMP_W-1:0] pos_ext;
  logic             accept;
  logic             in_range;
  logic             full;
  alid_cmd_t        op_cmd;

  assign in_ready = (state_r == S_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;
  assign pos_ext  = CMP_W'(in_position);
  assign pos_idx  = pos_ext[IDX_W-1:0];
  assign tail_idx = count_r[IDX_W-1:0];
  assign in_range = pos_ext < CMP_W'(count_r);
  assign full     = count_r == CNT_W'(CAPACITY);

  always_comb begin
    op_cmd     = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (in_opcode)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op_cmd.write_tail = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op_cmd.rd = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op_cmd.shift_down = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op_cmd.shift_up = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd      = accept ? op_cmd : '0;
    cmd.load = accept;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_HOLD;
      S_HOLD: if (out_ready && !accept) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_count_r <= count_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid         = (state_r == S_HOLD);
  assign out_element_count = res_count_r;
  assign out_status        = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.shift_down, cmd.shift_up, cmd.write_tail, cmd.rd}))
    else $error("more than one datapath action in a cycle");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt == ST_FULL |=> count_r == CNT_W'(CAPACITY))
    else $error("full status while list not full");

  a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op_cmd.write_tail || op_cmd.shift_up) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count did not grow by one");

endmodule

[hdl/alid_dpath.sv]
// datapath: row of element cells with shift paths, read select and read data register
module alid_dpath
  import alid_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                         clk,
  input  alid_cmd_t                    cmd,
  input  logic        [IDX_W-1:0]      pos_idx,
  input  logic        [IDX_W-1:0]      tail_idx,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic signed [DATA_WIDTH-1:0] out_read_value
);

  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];
  logic [DATA_WIDTH-1:0] read_value_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    logic [DATA_WIDTH-1:0] lower;
    logic                  at_pos;
    logic                  above_pos;

    // end cells wrap to themselves; those paths are never taken
    assign upper     = cells_r[(i + 1 < CAPACITY) ? i + 1 : i];
    assign lower     = cells_r[(i > 0) ? i - 1 : i];
    assign at_pos    = pos_idx == IDX_W'(i);
    assign above_pos = IDX_W'(i) > pos_idx;

    always_ff @(posedge clk) begin
      if (cmd.shift_down && (at_pos || above_pos) && (i + 1 < CAPACITY)) begin
        cells_r[i] <= upper;
      end else if (cmd.shift_up && above_pos) begin
        cells_r[i] <= lower;
      end else if (cmd.shift_up && at_pos) begin
        cells_r[i] <= in_value;
      end else if (cmd.write_tail && tail_idx == IDX_W'(i)) begin
        cells_r[i] <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_value_r <= cmd.rd ? cells_r[pos_idx] : '0;
    end
  end

  assign out_read_value = read_value_r;

endmodule

[hdl/array_list_insert_delete_core.sv]
// top level of the array list core: controller plus cell datapath
// Ordered list of up to CAPACITY elements kept in a row of registers. Every beat carries
// an opcode (append, read, delete, insert, clear), a position and a value and returns one
// result beat with the read value, the count after the operation and a status (ok,
// position not below count, list full). The whole row of cells shifts in the cycle of
// acceptance, and the result is registered and presented the next cycle. A new beat is
// accepted in the same cycle that the pending result is taken, so the sustained rate is
// one beat per cycle when the result side never stalls.
module array_list_insert_delete_core
  import alid_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IDX_W     = $clog2(CAPACITY)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [OPC_W-1:0]      in_opcode,
  input  logic        [POS_W-1:0]      in_position,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_read_value,
  output logic        [CNT_W-1:0]      out_element_count,
  output logic        [ST_W-1:0]       out_status
);

  alid_cmd_t        cmd;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] tail_idx;

  alid_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_element_count (out_element_count),
    .out_status        (out_status),
    .cmd               (cmd),
    .pos_idx           (pos_idx),
    .tail_idx          (tail_idx)
  );

  alid_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .pos_idx        (pos_idx),
    .tail_idx       (tail_idx),
    .in_value       (in_value),
    .out_read_value (out_read_value)
  );

endmodule

[dv/array_list_insert_delete_core_test.sv]
// testbench for the array list core: shadow list predictor, directed and random op streams
`timescale 1ns / 1ps

module array_list_insert_delete_core_test;
  import alid_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 6;

  // opcodes the block treats as no-ops
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;
    logic [ST_W-1:0]          status;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OPC_W-1:0]         in_opcode;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]         out_element_count;
  logic [ST_W-1:0]          out_status;

  // shadow copy of the list contents and length
  logic signed [DATA_W-1:0] shadow_cells [LIST_DEPTH];
  int unsigned              shadow_count;
  list_result_t             pending_results[$];

  int   error_count;
  logic calm;
  logic hold_req;
  logic hold_done;

  array_list_insert_delete_core #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(DATA_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_element_count(out_element_count),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // apply one accepted op to the shadow list and queue the expected result
  task automatic apply_list_op(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int i;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_cells[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_READ: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_cells[pos];
      end
      OP_DELETE: begin
        if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_count--;
        end
      end
      OP_INSERT: begin
        // position check wins over the full check
        if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[pos] = val;
          shadow_count++;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.element_count = shadow_count[CNT_W-1:0];
    pending_results.push_back(res);
  endtask

  // offer one beat, wait for acceptance; valid stays high for back-to-back beats
  task automatic send_beat(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    logic ready_seen;
    if (!calm && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 2);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= val;
    // ready is stable mid-cycle, so sample it there for the coming edge
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    apply_list_op(op, pos, val);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // result checker, sampled mid-cycle for the beat taken at the next edge
  always @(negedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: value %0d count %0d status %0d",
               out_read_value, out_element_count, out_status);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_read_value !== exp_res.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_res.read_value, out_read_value);
          error_count++;
        end
        if (out_element_count !== exp_res.element_count) begin
          $error("element_count: expected %0d, got %0d", exp_res.element_count,
                 out_element_count);
          error_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          error_count++;
        end
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  task automatic test_empty_list();
    send_beat(OP_READ, 4'd0, '0);
    send_beat(OP_INSERT, 4'd0, 32'sd5);
    send_beat(OP_SPARE_LO + 3'd1, 4'd15, '1);
  endtask

  task automatic test_fill_and_full();
    int k;
    send_beat(OP_APPEND, 4'd0, {1'b1, {(DATA_W-1){1'b0}}});
    send_beat(OP_APPEND, 4'd15, {1'b0, {(DATA_W-1){1'b1}}});
    send_beat(OP_APPEND, 4'd0, '1);
    send_beat(OP_APPEND, 4'd0, '0);
    for (k = 4; k < LIST_DEPTH; k++) send_beat(OP_APPEND, 4'(k), $urandom);
    send_beat(OP_APPEND, 4'd0, 32'sd77);
    send_beat(OP_INSERT, 4'd3, 32'sd99);
    send_beat(OP_READ, 4'd15, '0);
    send_beat(OP_DELETE, 4'd15, '0);
    send_beat(OP_INSERT, 4'd0, {1'b1, {(DATA_W-1){1'b0}}});
    send_beat(OP_DELETE, 4'd0, '0);
    send_beat(OP_CLEAR, 4'd0, '0);
  endtask

  // mostly in-range ops on a live list, some out-of-range, spare and clear noise
  task automatic test_random_ops(input int n_items, input int append_weight);
    logic [OPC_W-1:0] op;
    logic [POS_W-1:0] pos;
    int roll;
    int k;
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < append_weight)           op = OP_APPEND;
      else if (roll < append_weight + 25) op = OP_READ;
      else if (roll < append_weight + 45) op = OP_INSERT;
      else if (roll < 94)                 op = OP_DELETE;
      else if (roll < 97)                 op = OP_CLEAR;
      else                                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (shadow_count > 0 && $urandom_range(0, 99) < 90)
        pos = 4'($urandom_range(0, shadow_count - 1));
      else
        pos = 4'($urandom_range(0, LIST_DEPTH - 1));
      send_beat(op, pos, pick_value());
    end
  endtask

  // block the result side while beats keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    test_random_ops(40, 40);
  endtask

  initial begin
    error_count = 0;
    shadow_count = 0;
    calm        <= 1'b0;
    hold_req    <= 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_APPEND;
    in_position <= '0;
    in_value    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_fill_and_full();
    test_random_ops(200, 40);
    calm <= 1'b1;
    test_random_ops(120, 55);
    calm <= 1'b0;
    test_output_backpressure();
    test_random_ops(120, 25);
    test_random_ops(100, 60);
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("array_list_insert_delete_core_test: done, clean");
    end else begin
      $display("array_list_insert_delete_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("array_list_insert_delete_core_test: done, errors");
    $finish;
  end

endmodule
